// ----- hw/rtl/sbpc_pkg.sv -----
// ============================================================================
// sbpc_pkg: shared types and constants for the seven-bit payload codec
// Result-unit operation codes, the control word the sequencer hands to the
// result unit, and the result word it passes on to the output register.
// ============================================================================
package sbpc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned GROUP_N = 7;

    localparam logic [IDX_W-1:0] POS_LAST_DATA = 3'd6;
    localparam logic [IDX_W-1:0] POS_FULL      = 3'd7;

    // operation of the shared result unit
    typedef enum logic [1:0] {
        MD_LOW7  = 2'd0,
        MD_TOP   = 2'd1,
        MD_MERGE = 2'd2
    } merge_mode_t;

    typedef struct packed {
        merge_mode_t      mode;
        logic [IDX_W-1:0] idx;
    } merge_ctrl_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } emit_t;

endpackage

// ----- hw/rtl/sbpc_merge.sv -----
// ============================================================================
// sbpc_merge: shared result unit
// Forms one result byte per cycle: the low seven bits of a raw byte, the
// gathered top bits, or a held byte with one top bit added back in.
// ============================================================================
module sbpc_merge (
    input  sbpc_pkg::merge_ctrl_t ctrl,
    input  logic [7:0]            held_byte,
    input  logic [7:0]            data_byte,
    input  logic [6:0]            top_bits,
    output logic [7:0]            result
);
    import sbpc_pkg::*;

    logic [7:0] add_term;

    // bit idx of the trailing byte moves up to bit 7
    assign add_term = {data_byte[ctrl.idx], 7'b0};

    always_comb
    begin
        case (ctrl.mode)
            MD_LOW7:  result = {1'b0, data_byte[6:0]};
            MD_TOP:   result = {1'b0, top_bits};
            MD_MERGE: result = held_byte + add_term;
            default:  result = '0;
        endcase
    end

endmodule

// ----- hw/rtl/sbpc_seq.sv -----
// ============================================================================
// sbpc_seq: group sequencer
// Tracks the group position, gathers top bits, holds decoded data bytes and
// steps the shared result unit once per result byte.
// ============================================================================
module sbpc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            direction,
    input  logic            in_valid,
    input  logic [7:0]      in_data,
    input  logic            in_last,
    output logic            in_ready,
    input  logic            out_free,
    output sbpc_pkg::emit_t emit
);
    import sbpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [6:0]       top_reg, top_next;
    logic [7:0]       data_reg, data_next;
    logic             last_reg, last_next;
    logic             dec_reg, dec_next;
    logic             close_reg, close_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       held_reg [GROUP_N];

    logic             accept;
    logic             flush;
    logic             held_we;
    logic             enc_close;
    logic             emit_valid;
    merge_ctrl_t      ctrl;
    logic [7:0]       result;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign flush     = (pos_reg == POS_FULL) || in_last;
    assign enc_close = (pos_reg >= POS_LAST_DATA) || in_last;
    assign held_we   = accept && direction && !flush;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        top_next   = top_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        dec_next   = dec_reg;
        close_next = close_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        emit_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next = in_data;
                    last_next = in_last;
                    dec_next  = direction;
                    idx_next  = '0;
                    if (!direction)
                    begin
                        // a top bit beyond the group is dropped
                        if (pos_reg != POS_FULL)
                        begin
                            top_next = top_reg | (7'(in_data[7]) << pos_reg);
                        end
                        close_next = enc_close;
                        cnt_next   = enc_close ? 3'd1 : 3'd0;
                        state_next = ST_EMIT;
                    end
                    else if (flush)
                    begin
                        if (pos_reg == '0)
                        begin
                            // last byte with nothing held
                            pos_next = '0;
                            top_next = '0;
                        end
                        else
                        begin
                            cnt_next   = pos_reg - 3'd1;
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                emit_valid = out_free;
                if (out_free)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == cnt_reg)
                    begin
                        state_next = ST_IDLE;
                        if (dec_reg || close_reg)
                        begin
                            pos_next = '0;
                            top_next = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.idx = idx_reg;
        if (dec_reg)
        begin
            ctrl.mode = MD_MERGE;
        end
        else if (idx_reg == '0)
        begin
            ctrl.mode = MD_LOW7;
        end
        else
        begin
            ctrl.mode = MD_TOP;
        end
    end

    sbpc_merge u_merge (
        .ctrl      (ctrl),
        .held_byte (held_reg[idx_reg]),
        .data_byte (data_reg),
        .top_bits  (top_reg),
        .result    (result)
    );

    assign emit = '{valid: emit_valid,
                    data:  result,
                    last:  last_reg && (idx_reg == cnt_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            top_reg   <= '0;
            last_reg  <= 1'b0;
            dec_reg   <= 1'b0;
            close_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            top_reg   <= top_next;
            last_reg  <= last_next;
            dec_reg   <= dec_next;
            close_reg <= close_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (held_we)
        begin
            held_reg[pos_reg] <= in_data;
        end
    end

endmodule

// ----- hw/rtl/seven_bit_payload_codec.sv -----
// ============================================================================
// seven_bit_payload_codec: 7-bit packing encoder / decoder
// Converts a byte message to or from 7-bit packed form.
// ============================================================================
// usage:
//   s_* carries input bytes (tdata = data byte, tlast = final byte of the
//   message); m_* carries result bytes (tdata = byte, tlast = final result
//   of the last input). cfg_we / cfg_wdata sets direction: 0 encodes,
//   1 decodes; write it only while no transaction is in flight.
// per input transaction:
//   encode: 1 result, or 2 when the group closes and the top-bit byte follows
//   decode, byte held: no result; decode, group flush of n held bytes: n
//   results; the sequencer drives one result per cycle through the shared
//   result unit while out_free is high; s_tready is low while it emits
// path: idle accepts, emit state emits, output register drives m_tvalid
// stalls: the output register holds its result while m_tready is low and
//   the sequencer waits; s_tready stays low until all results are loaded
// reset: direction returns to encode, group position and gathered top
//   bits clear, m_tvalid drops; held bytes are undefined until written
// ============================================================================
module seven_bit_payload_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import sbpc_pkg::*;

    logic       direction_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_free;
    emit_t      emit;

    assign out_free = !out_valid_reg || m_tready;

    sbpc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (direction_reg),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .emit      (emit)
    );

    always_comb
    begin
        if (emit.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                direction_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_data_reg <= emit.data;
            out_last_reg <= emit.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hw/rtl/sbpc_checker.sv -----
// ============================================================================
// sbpc_checker: port-level checks for the seven-bit payload codec
// Watches the stream and configuration ports and is bound to the top level.
// ============================================================================
module sbpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic       cfg_wdata,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    logic dir_reg;
    logic s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    // mirror of the direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            dir_reg <= cfg_wdata;
        end
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // every encoded byte makes at least one result, so the input closes
    a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && !dir_reg |=> !s_tready)
        else $error("input ready right after an encode transaction");

    // the last byte of a message also sends the top-bit byte
    a_enc_close: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && !dir_reg && s_tlast && !$isunknown(s_tdata) |=> !s_tready [*2])
        else $error("last encode transaction finished without the top-bit result");

endmodule

bind seven_bit_payload_codec sbpc_checker u_sbpc_checker (.*);
